[hdl/burnd_pkg.sv]
// package with constants, types and helper functions of the bounded random unit
package burnd_pkg;

  localparam int unsigned MtN         = 624;
  localparam int unsigned MtM         = 397;
  localparam int unsigned IdxW        = 10;
  localparam logic [31:0] MtMatrix    = 32'h9908_B0DF;
  localparam logic [31:0] MtInitMul   = 32'd1812433253;
  localparam logic [31:0] SeedReset   = 32'd5489;
  localparam int unsigned MaxTriesDef = 20;

  typedef enum logic [0:0] {
    CMD_SIGNED   = 1'b0,
    CMD_UNSIGNED = 1'b1
  } cmd_e;

  // classified request handed from the front to the back
  typedef struct packed {
    logic        direct;
    logic [63:0] direct_value;
    logic [63:0] offset;
    logic [63:0] bnd;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_START,
    BK_SETUP,
    BK_DIV,
    BK_FETCH,
    BK_WAIT,
    BK_CHECK,
    BK_MOD,
    BK_DONE,
    BK_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    MT_SEED,
    MT_SEED_MUL,
    MT_READY,
    MT_REGEN_RD,
    MT_REGEN_WR,
    MT_RD,
    MT_RD_WAIT
  } mt_state_e;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[hdl/burnd_if.sv]
// valid/ready channel interfaces for requests and results
interface burnd_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] lo;
  logic [63:0] hi;
  logic [63:0] bound;
  modport source (output valid, cmd, lo, hi, bound, input ready);
  modport sink (input valid, cmd, lo, hi, bound, output ready);
endinterface

interface burnd_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        fallback_used;
  modport source (output valid, value, fallback_used, input ready);
  modport sink (input valid, value, fallback_used, output ready);
endinterface

[hdl/burnd_front.sv]
// front end: accepts requests, classifies them and fills a two-entry queue
module burnd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  burnd_req_if.sink         req,
  output logic              job_valid_o,
  input  logic              job_pop_i,
  output burnd_pkg::job_t   job_o
);
  burnd_pkg::job_t fifo_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  burnd_pkg::job_t cls;
  logic            push;

  always_comb begin
    cls              = '0;
    cls.direct_value = req.lo;
    cls.offset       = '0;
    cls.bnd          = req.bound;
    if (req.cmd == burnd_pkg::CMD_SIGNED) begin
      cls.offset = req.lo;
      cls.bnd    = req.hi - req.lo;
      cls.direct = ($signed(req.lo) >= $signed(req.hi));
    end else begin
      cls.direct_value = '0;
      cls.direct       = (req.bound == '0);
    end
  end

  assign req.ready   = (cnt_q != 2'd2);
  assign push        = req.valid && req.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (job_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop_i};
    end
  end
endmodule

[hdl/burnd_mt.sv]
// mt19937 word source with single-port state memory, seeding and regeneration
module burnd_mt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        req_i,
  output logic        ack_o,
  output logic [31:0] word_o
);
  localparam logic [9:0] LastIdx = 10'(burnd_pkg::MtN - 1);
  localparam logic [9:0] MIdx    = 10'(burnd_pkg::MtM);
  localparam logic [9:0] NIdx    = 10'(burnd_pkg::MtN);

  logic [31:0] mem [burnd_pkg::MtN];
  logic [31:0] rd_q;
  logic [9:0]  raddr;
  logic        re;
  logic        we;
  logic [9:0]  waddr;
  logic [31:0] wdata;

  burnd_pkg::mt_state_e st_q, st_d;
  logic [9:0]  idx_q, idx_d;
  logic [9:0]  i_q, i_d;
  logic [1:0]  ph_q, ph_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [31:0] mul_q;
  logic [31:0] y, v;
  logic [9:0]  i1, im;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
    mul_q <= burnd_pkg::MtInitMul * (prev_q ^ (prev_q >> 30));
  end

  assign i1 = (i_q == LastIdx) ? 10'd0 : i_q + 10'd1;
  assign im = (i_q >= NIdx - MIdx) ? i_q - (NIdx - MIdx) : i_q + MIdx;
  assign y  = (a_q & 32'h8000_0000) | (b_q & 32'h7FFF_FFFF);
  assign v  = rd_q ^ (y >> 1) ^ (y[0] ? burnd_pkg::MtMatrix : 32'h0);
  assign word_o = burnd_pkg::temper(rd_q);

  always_comb begin
    st_d = st_q; idx_d = idx_q; i_d = i_q; ph_d = ph_q;
    prev_d = prev_q; a_d = a_q; b_d = b_q;
    re = 1'b0; raddr = i_q; we = 1'b0; waddr = i_q; wdata = prev_q;
    ack_o = 1'b0;
    if (seed_we_i) begin
      st_d = burnd_pkg::MT_SEED_MUL; i_d = 10'd1; prev_d = seed_i;
      idx_d = NIdx; we = 1'b1; waddr = 10'd0; wdata = seed_i; ph_d = 2'd0;
    end else begin
      unique case (st_q)
        burnd_pkg::MT_SEED: begin
          // seed word 0 is written with the reset seed in the state entered at reset
          we = 1'b1; waddr = 10'd0;
          st_d = burnd_pkg::MT_SEED_MUL;
        end
        burnd_pkg::MT_SEED_MUL: begin
          if (ph_q == 2'd0) ph_d = 2'd1;
          else begin
            we = 1'b1; wdata = mul_q + {22'd0, i_q}; prev_d = mul_q + {22'd0, i_q};
            ph_d = 2'd0;
            if (i_q == LastIdx) st_d = burnd_pkg::MT_READY;
            else i_d = i_q + 10'd1;
          end
        end
        burnd_pkg::MT_READY: begin
          if (req_i) begin
            if (idx_q == NIdx) begin
              st_d = burnd_pkg::MT_REGEN_RD; i_d = 10'd0; ph_d = 2'd0;
            end else st_d = burnd_pkg::MT_RD;
          end
        end
        burnd_pkg::MT_REGEN_RD: begin
          // three reads: word i, word i+1, word i+m
          re = 1'b1;
          unique case (ph_q)
            2'd0: begin raddr = i_q; ph_d = 2'd1; end
            2'd1: begin raddr = i1; a_d = rd_q; ph_d = 2'd2; end
            2'd2: begin raddr = im; a_d = rd_q; ph_d = 2'd3; end
            default: begin re = 1'b0; b_d = rd_q; ph_d = 2'd0;
              st_d = burnd_pkg::MT_REGEN_WR; end
          endcase
          if (ph_q == 2'd1) a_d = a_q;
          if (ph_q == 2'd2) a_d = a_q;
          if (ph_q == 2'd1) a_d = rd_q;
          if (ph_q == 2'd2) begin a_d = a_q; b_d = rd_q; end
          if (ph_q == 2'd3) b_d = b_q;
        end
        burnd_pkg::MT_REGEN_WR: begin
          we = 1'b1; wdata = v;
          if (i_q == LastIdx) begin
            st_d = burnd_pkg::MT_RD; idx_d = 10'd0;
          end else begin
            i_d = i_q + 10'd1; st_d = burnd_pkg::MT_REGEN_RD;
          end
        end
        burnd_pkg::MT_RD: begin
          re = 1'b1; raddr = idx_q; idx_d = idx_q + 10'd1;
          st_d = burnd_pkg::MT_RD_WAIT;
        end
        burnd_pkg::MT_RD_WAIT: begin
          ack_o = 1'b1; st_d = burnd_pkg::MT_READY;
        end
        default: st_d = burnd_pkg::MT_READY;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= burnd_pkg::MT_SEED; idx_q <= NIdx; i_q <= 10'd1; ph_q <= 2'd0;
      prev_q <= burnd_pkg::SeedReset;
    end else begin
      st_q <= st_d; idx_q <= idx_d; i_q <= i_d; ph_q <= ph_d; prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d;
  end
endmodule

[hdl/burnd_divu.sv]
// 33-bit restoring divider, one quotient bit per cycle, remainder out
module burnd_divu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [32:0] rem_o
);
  logic [32:0] n_q, d_q;
  logic [33:0] r_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [33:0] sh;

  assign sh     = {r_q[32:0], n_q[32]};
  assign rem_o  = r_q[32:0];
  assign done_o = busy_q && (cnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 6'd33;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i; d_q <= den_i; r_q <= '0;
    end else if (busy_q && cnt_q != 6'd0) begin
      n_q <= {n_q[31:0], 1'b0};
      r_q <= (sh >= {1'b0, d_q}) ? sh - {1'b0, d_q} : sh;
    end
  end
endmodule

[hdl/burnd_back.sv]
// back end: bounded draws by masking or rejection with modulo fallback
module burnd_back #(
  parameter int unsigned MaxTries = burnd_pkg::MaxTriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  input  burnd_pkg::job_t  job_i,
  output logic             word_req_o,
  input  logic             word_ack_i,
  input  logic [31:0]      word_i,
  burnd_rsp_if.source      rsp
);
  localparam int unsigned TryW = $clog2(MaxTries + 1);

  burnd_pkg::back_state_e st_q, st_d;
  burnd_pkg::job_t job_q;
  logic        half_q;       // 0 high half, 1 low half
  logic [31:0] m_q;
  logic [31:0] g_q;
  logic [31:0] r_q;
  logic [31:0] hr_q;
  logic        fb_q;
  logic [TryW-1:0] fails_q;
  logic        divmode_q;    // a reduction is running in the divider
  logic        modg_q;       // next reduction is the fallback mod g
  logic [63:0] val_q;        // finished value waiting for the result register
  logic [63:0] out_q;
  logic        out_fb_q;
  logic        ov_q;

  logic        div_start;
  logic [32:0] div_num, div_den;
  logic        div_done;
  logic [32:0] div_rem;
  logic [32:0] range;
  logic        m_zero;
  logic        m_full;
  logic        rej;
  logic        last_try;
  logic [31:0] res;

  assign range    = {1'b0, m_q} + 33'd1;
  assign m_zero   = (m_q == 32'h0);
  assign m_full   = (m_q == 32'hFFFF_FFFF);
  // rejection only when the span is not a power of two
  assign rej      = ((range[31:0] & m_q) != 32'h0);
  assign last_try = (32'(fails_q) + 32'd1 >= 32'(MaxTries));

  burnd_divu u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .rem_o(div_rem)
  );

  assign rsp.valid         = ov_q;
  assign rsp.value         = out_q;
  assign rsp.fallback_used = out_fb_q;

  always_comb begin
    res = r_q;
    if (m_zero) res = 32'h0;
    else if (!m_full && !rej) res = r_q & m_q;
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      burnd_pkg::BK_IDLE: if (job_valid_i) st_d = burnd_pkg::BK_START;
      burnd_pkg::BK_START: begin
        if (job_q.direct) st_d = burnd_pkg::BK_DONE;
        else st_d = burnd_pkg::BK_SETUP;
      end
      burnd_pkg::BK_SETUP: begin
        if (m_zero) st_d = burnd_pkg::BK_OUT;
        else if (!rej) st_d = burnd_pkg::BK_FETCH;
        else st_d = burnd_pkg::BK_DIV;
      end
      burnd_pkg::BK_DIV: if (div_done) st_d = burnd_pkg::BK_FETCH;
      burnd_pkg::BK_FETCH: st_d = burnd_pkg::BK_WAIT;
      burnd_pkg::BK_WAIT: if (word_ack_i) st_d = burnd_pkg::BK_CHECK;
      burnd_pkg::BK_CHECK: begin
        if (!rej) st_d = burnd_pkg::BK_OUT;
        else if (r_q >= g_q && !last_try) st_d = burnd_pkg::BK_FETCH;
        else st_d = burnd_pkg::BK_MOD;
      end
      burnd_pkg::BK_MOD: begin
        if (divmode_q && div_done && !modg_q) st_d = burnd_pkg::BK_OUT;
      end
      burnd_pkg::BK_OUT: begin
        if (half_q) st_d = burnd_pkg::BK_DONE;
        else st_d = burnd_pkg::BK_SETUP;
      end
      burnd_pkg::BK_DONE: if (!ov_q) st_d = burnd_pkg::BK_IDLE;
      default: st_d = burnd_pkg::BK_IDLE;
    endcase
  end

  // outputs toward the queue, the twister and the divider
  always_comb begin
    job_pop_o  = 1'b0;
    word_req_o = 1'b0;
    div_start  = 1'b0;
    div_num    = {1'b0, 32'hFFFF_FFFF};
    div_den    = range;
    unique case (st_q)
      burnd_pkg::BK_IDLE:  job_pop_o = job_valid_i;
      burnd_pkg::BK_SETUP: div_start = rej;
      burnd_pkg::BK_FETCH: word_req_o = 1'b1;
      // request held until the twister answers, it may still be seeding
      burnd_pkg::BK_WAIT:  word_req_o = !word_ack_i;
      burnd_pkg::BK_MOD: begin
        if (!divmode_q) begin
          div_start = 1'b1;
          div_num   = {1'b0, r_q};
          div_den   = modg_q ? {1'b0, g_q} : range;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= burnd_pkg::BK_IDLE; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == burnd_pkg::BK_DONE && !ov_q) ov_q <= 1'b1;
      else if (rsp.valid && rsp.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      burnd_pkg::BK_IDLE: if (job_valid_i) job_q <= job_i;
      burnd_pkg::BK_START: begin
        half_q <= 1'b0; fb_q <= 1'b0; hr_q <= '0;
        m_q <= job_q.bnd[63:32];
        val_q <= job_q.direct_value;
      end
      burnd_pkg::BK_SETUP: begin
        fails_q <= '0; divmode_q <= 1'b0; modg_q <= 1'b0;
      end
      burnd_pkg::BK_DIV: if (div_done) g_q <= 32'hFFFF_FFFF - div_rem[31:0];
      burnd_pkg::BK_WAIT: if (word_ack_i) r_q <= word_i;
      burnd_pkg::BK_CHECK: begin
        if (rej && r_q >= g_q) begin
          fails_q <= fails_q + TryW'(1);
          if (last_try) begin
            modg_q <= 1'b1; fb_q <= 1'b1;
          end
        end
      end
      burnd_pkg::BK_MOD: begin
        if (!divmode_q) divmode_q <= 1'b1;
        else if (div_done) begin
          divmode_q <= 1'b0; modg_q <= 1'b0; r_q <= div_rem[31:0];
        end
      end
      burnd_pkg::BK_OUT: begin
        if (!half_q) begin
          hr_q <= res; half_q <= 1'b1;
          if (res == job_q.bnd[63:32]) m_q <= job_q.bnd[31:0];
          else m_q <= 32'hFFFF_FFFF;
        end else begin
          val_q <= job_q.offset + {hr_q, res};
        end
      end
      burnd_pkg::BK_DONE: begin
        if (!ov_q) begin
          out_q <= val_q; out_fb_q <= fb_q;
        end
      end
      default: ;
    endcase
  end
endmodule

[hdl/bounded_uniform_random_integer_unit.sv]
// top level of the bounded uniform random integer unit
// usage:
//   req channel: one beat per request, cmd selects a signed range lo..hi or
//   an unsigned range 0..bound; a two-entry queue sits behind the front end
//   rsp channel: one beat per request with the value and the fallback flag
//   cfg_we_i/cfg_wdata_i: write enable plus data; reseeds the twister; user must do so only while idle, not enforced
// draw path:
//   a request with no draw goes straight to the result register;
//   each 32-bit draw fetches words from the twister; when the span is not a
//   power of two it uses the shared divider for the threshold and each reduction;
//   a word that falls due for regeneration waits while the twister rebuilds
//   its whole state in the single-port state memory
// reset:
//   after reset the twister seeds itself from 5489, writing all 624 state words;
//   requests are queued meanwhile
// stall:
//   the result register holds its beat until taken; the back end then waits
//   and the front end keeps taking requests until its queue is full
module bounded_uniform_random_integer_unit #(
  parameter int unsigned MaxTries = burnd_pkg::MaxTriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  burnd_req_if.sink   req,
  burnd_rsp_if.source rsp,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  logic            job_valid, job_pop;
  burnd_pkg::job_t job;
  logic            word_req, word_ack;
  logic [31:0]     word;

  burnd_front u_front (
    .clk_i, .rst_ni, .req, .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  burnd_mt u_mt (
    .clk_i, .rst_ni, .seed_we_i(cfg_we_i), .seed_i(cfg_wdata_i),
    .req_i(word_req), .ack_o(word_ack), .word_o(word)
  );

  burnd_back #(.MaxTries(MaxTries)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .word_req_o(word_req), .word_ack_i(word_ack), .word_i(word), .rsp
  );
endmodule
